// File: rtl/jsce_pkg.sv
// jsce_pkg: shared types, character constants and helpers for the JSON string
// control-character escaper. No dependencies.
package jsce_pkg;

  // One input request: a text byte and its end-of-text mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  // One output result byte.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;
  } out_item_t;

  typedef enum logic {
    CMD_PASS   = 1'b0,
    CMD_ESCAPE = 1'b1
  } cmd_kind_e;

  // Classified command handed from the front to the back through the queue.
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       eot;
  } cmd_t;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharU      = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharOne    = 8'h31;
  localparam logic [7:0] CtrlLimit  = 8'h20;

  // Position of each byte inside the six-byte \u00XX sequence.
  localparam int unsigned IdxW = 3;
  localparam logic [IdxW-1:0] IdxBslash = 3'd0;
  localparam logic [IdxW-1:0] IdxU      = 3'd1;
  localparam logic [IdxW-1:0] IdxZero0  = 3'd2;
  localparam logic [IdxW-1:0] IdxZero1  = 3'd3;
  localparam logic [IdxW-1:0] IdxHexHi  = 3'd4;
  localparam logic [IdxW-1:0] IdxHexLo  = 3'd5;

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'h0, nib};
    end else begin
      ch = 8'h57 + {4'h0, nib};
    end
    return ch;
  endfunction

endpackage

// File: rtl/jsce_front.sv
// jsce_front: accepts input requests, tracks string/escape state and
// classifies each byte as pass-through or \u00XX escape. Uses jsce_pkg.
module jsce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jsce_pkg::in_item_t in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output jsce_pkg::cmd_t     push_cmd_o
);

  logic inside_q, inside_d;
  logic esc_q, esc_d;
  logic accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  always_comb begin
    inside_d        = inside_q;
    esc_d           = esc_q;
    push_cmd_o.kind = jsce_pkg::CMD_PASS;
    push_cmd_o.data = in_data_i.in_byte;
    push_cmd_o.eot  = in_data_i.end_of_text;
    if (!inside_q) begin
      if (in_data_i.in_byte == jsce_pkg::CharQuote) begin
        inside_d = 1'b1;
      end
    end else if (esc_q) begin
      esc_d = 1'b0;
    end else if (in_data_i.in_byte == jsce_pkg::CharBslash) begin
      esc_d = 1'b1;
    end else if (in_data_i.in_byte == jsce_pkg::CharQuote) begin
      inside_d = 1'b0;
    end else if (in_data_i.in_byte < jsce_pkg::CtrlLimit) begin
      push_cmd_o.kind = jsce_pkg::CMD_ESCAPE;
    end
    // End of text drops both states after this byte.
    if (in_data_i.end_of_text) begin
      inside_d = 1'b0;
      esc_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
    end else if (accept) begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
    end
  end

endmodule

// File: rtl/jsce_queue.sv
// jsce_queue: small FIFO of classified commands between front and back.
// Uses jsce_pkg for the command type.
module jsce_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsce_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jsce_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsce_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jsce_back.sv
// jsce_back: expands queued commands into output bytes, one per cycle unless
// out_ready_i stalls it, into a registered output stage. Uses jsce_pkg.
module jsce_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  jsce_pkg::cmd_t      q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jsce_pkg::out_item_t out_data_o
);

  logic [jsce_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      out_valid_q;
  jsce_pkg::out_item_t       out_data_q, out_data_d;
  logic                      load, is_last;
  logic [7:0]                esc_byte;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (q_head_i.kind == jsce_pkg::CMD_PASS) || (idx_q == jsce_pkg::IdxHexLo);
  assign q_pop_o = load && is_last;

  always_comb begin
    case (idx_q)
      jsce_pkg::IdxBslash: esc_byte = jsce_pkg::CharBslash;
      jsce_pkg::IdxU:      esc_byte = jsce_pkg::CharU;
      jsce_pkg::IdxZero0:  esc_byte = jsce_pkg::CharZero;
      jsce_pkg::IdxZero1:  esc_byte = jsce_pkg::CharZero;
      jsce_pkg::IdxHexHi:  esc_byte = jsce_pkg::hex_lower(q_head_i.data[7:4]);
      default:             esc_byte = jsce_pkg::hex_lower(q_head_i.data[3:0]);
    endcase
  end

  always_comb begin
    out_data_d.out_byte = (q_head_i.kind == jsce_pkg::CMD_ESCAPE) ? esc_byte : q_head_i.data;
    out_data_d.run_last = is_last;
    out_data_d.text_end = is_last && q_head_i.eot;
    idx_d               = is_last ? jsce_pkg::IdxBslash : idx_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= jsce_pkg::IdxBslash;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= idx_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/json_string_control_char_escaper.sv
// json_string_control_char_escaper: top level of the JSON string escaper.
// Instantiates jsce_front, jsce_queue and jsce_back; uses jsce_pkg.
//
//   channel | direction | handshake               | payload
//   in      | request   | in_valid_i / in_ready_o   | in_data_i  (in_byte, end_of_text)
//   out     | result    | out_valid_o / out_ready_i | out_data_o (out_byte, run_last, text_end)
//
// Input takes one request per cycle while the command queue has room.
// Output gives one byte per cycle while out_ready_i is high: one for a pass byte, six for a \u00XX escape,
// so sustained input rate is set by the back end's byte count per request.
// An accepted request passes the command queue, then the registered output stage, before its first result byte.
// Reset clears string state, queue and output stage at once; no clearing pass.
// Output stalls fill the queue (QueueDepth requests) before in_ready_o drops.
module json_string_control_char_escaper #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  jsce_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jsce_pkg::out_item_t out_data_o
);

  logic           q_full, q_push, q_pop, q_valid;
  jsce_pkg::cmd_t push_cmd, head_cmd;

  jsce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (push_cmd)
  );

  jsce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  jsce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/jsce_checker.sv
// jsce_checker: port-level assertions for json_string_control_char_escaper,
// bound to the top level. Uses jsce_pkg.
module jsce_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input jsce_pkg::out_item_t out_data_o
);

  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // End of text only on the final byte of a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.text_end |-> out_data_o.run_last)
    else $error("text_end without run_last");

  // Non-final bytes only come from an escape sequence prefix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.run_last |->
      (out_data_o.out_byte == jsce_pkg::CharBslash) ||
      (out_data_o.out_byte == jsce_pkg::CharU) ||
      (out_data_o.out_byte == jsce_pkg::CharZero) ||
      (out_data_o.out_byte == jsce_pkg::CharOne))
    else $error("unexpected byte inside escape sequence");

  // Nothing is presented right after reset releases.
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind json_string_control_char_escaper jsce_checker u_jsce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: sim/tb_json_string_control_char_escaper.sv
// Testbench for json_string_control_char_escaper: directed and random JSON text
// through the valid/ready channels, checked against a scoreboard.
// Depends on jsce_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_json_string_control_char_escaper;

  localparam int unsigned RandomItems = 200;
  localparam int unsigned CalmAfter   = 165;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 16;

  // Tracks string state and holds the escaped bytes still owed by the block.
  class escape_scoreboard;
    jsce_pkg::out_item_t expected_bytes[$];
    bit        str_open;
    bit        escape_armed;
    int        errors;

    function new();
      str_open     = 1'b0;
      escape_armed = 1'b0;
      errors       = 0;
    endfunction

    function logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib > 4'd9) begin
        ch = "a" + 8'(nib - 4'd10);
      end else begin
        ch = "0" + 8'(nib);
      end
      return ch;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void note_request(input jsce_pkg::in_item_t req);
      logic [7:0] emitted[$];
      jsce_pkg::out_item_t res;
      logic [7:0] b;
      b = req.in_byte;
      if (!str_open) begin
        emitted.push_back(b);
        if (b == jsce_pkg::CharQuote) str_open = 1'b1;
      end else if (escape_armed) begin
        emitted.push_back(b);
        escape_armed = 1'b0;
      end else if (b == jsce_pkg::CharBslash) begin
        emitted.push_back(b);
        escape_armed = 1'b1;
      end else if (b == jsce_pkg::CharQuote) begin
        emitted.push_back(b);
        str_open = 1'b0;
      end else if (b < jsce_pkg::CtrlLimit) begin
        emitted.push_back(jsce_pkg::CharBslash);
        emitted.push_back(jsce_pkg::CharU);
        emitted.push_back(jsce_pkg::CharZero);
        emitted.push_back(jsce_pkg::CharZero);
        emitted.push_back(hex_digit(b[7:4]));
        emitted.push_back(hex_digit(b[3:0]));
      end else begin
        emitted.push_back(b);
      end
      foreach (emitted[i]) begin
        res.out_byte = emitted[i];
        res.run_last = (i == emitted.size() - 1);
        res.text_end = (i == emitted.size() - 1) && req.end_of_text;
        expected_bytes.push_back(res);
      end
      if (req.end_of_text) begin
        str_open     = 1'b0;
        escape_armed = 1'b0;
      end
    endfunction

    function void check_result(input jsce_pkg::out_item_t got);
      jsce_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last mismatch: expected %b, actual %b",
                 $time, want.run_last, got.run_last);
        errors++;
      end
      if (got.text_end !== want.text_end) begin
        $display("%0t: text_end mismatch: expected %b, actual %b",
                 $time, want.text_end, got.text_end);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  jsce_pkg::in_item_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  jsce_pkg::out_item_t out_data_o;

  escape_scoreboard sb;
  bit          calm_tail = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned stall_left = 0;

  json_string_control_char_escaper u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Observe both handshakes with pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stall bursts, none in the calm tail.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
      stall_left  <= $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  function automatic jsce_pkg::in_item_t mk(input logic [7:0] b, input logic eot);
    jsce_pkg::in_item_t req;
    req.in_byte     = b;
    req.end_of_text = eot;
    return req;
  endfunction

  function automatic int unsigned pick_gap();
    if (!calm_tail && $urandom_range(0, 7) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  // Hold the request until accepted; drop valid only across a gap.
  task automatic send_request(input jsce_pkg::in_item_t req, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // Drop valid, let the last request reach the scoreboard, then wait it out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == jsce_pkg::CharQuote || c == jsce_pkg::CharBslash) c = ":";
    return c;
  endfunction

  // Text of plain bytes and strings with escapes and control bytes; a string may be left unclosed.
  task automatic send_text();
    logic [7:0] txt[$];
    int unsigned segs;
    int unsigned len;
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      repeat ($urandom_range(0, 3)) txt.push_back(plain_char());
      txt.push_back(jsce_pkg::CharQuote);
      len = $urandom_range(0, 6);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2: txt.push_back(8'($urandom_range(0, 31)));
          3: begin
            txt.push_back(jsce_pkg::CharBslash);
            txt.push_back(8'($urandom));
          end
          4, 5: txt.push_back(8'($urandom_range(128, 255)));
          default: txt.push_back(plain_char());
        endcase
      end
      if ($urandom_range(0, 5) != 0) txt.push_back(jsce_pkg::CharQuote);
    end
    foreach (txt[i]) send_request(mk(txt[i], i == txt.size() - 1), pick_gap());
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_request(mk(8'($urandom), $urandom_range(0, 7) == 0), pick_gap());
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: bytes outside a string pass, including zero and backslash.
    send_request(mk("a", 1'b0), 0);
    send_request(mk(8'h00, 1'b0), 0);
    send_request(mk(8'hFF, 1'b0), 0);
    send_request(mk(jsce_pkg::CharBslash, 1'b0), 0);
    send_request(mk(jsce_pkg::CharQuote, 1'b0), 0);
    // Inside: control bytes expand, others pass.
    send_request(mk(8'h00, 1'b0), 0);
    send_request(mk(8'h1F, 1'b0), 0);
    send_request(mk(8'h0A, 1'b0), 0);
    send_request(mk(8'h20, 1'b0), 0);
    send_request(mk(8'hFF, 1'b0), 0);
    send_request(mk(8'h7F, 1'b0), 0);
    // Escaped quote, backslash and control byte pass verbatim.
    send_request(mk(jsce_pkg::CharBslash, 1'b0), 0);
    send_request(mk(jsce_pkg::CharQuote, 1'b0), 0);
    send_request(mk(jsce_pkg::CharBslash, 1'b0), 0);
    send_request(mk(jsce_pkg::CharBslash, 1'b0), 0);
    send_request(mk(jsce_pkg::CharBslash, 1'b0), 0);
    send_request(mk(8'h01, 1'b0), 0);
    send_request(mk(jsce_pkg::CharQuote, 1'b0), 0);
    // Backslash at end of text drops the pending escape.
    send_request(mk(jsce_pkg::CharQuote, 1'b0), 0);
    send_request(mk("x", 1'b0), 0);
    send_request(mk(jsce_pkg::CharBslash, 1'b1), 0);
    send_request(mk(jsce_pkg::CharQuote, 1'b0), 0);
    // End of text inside a string on a control byte; next byte is outside.
    send_request(mk(8'h05, 1'b1), 0);
    send_request(mk(8'h03, 1'b0), 0);
    send_request(mk(8'h10, 1'b1), 0);
    wait_drained();

    sent = 0;
    while (sent < RandomItems) begin
      if (!paused && sent >= RandomItems / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      if (sent >= CalmAfter) calm_tail = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        send_text();
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: json_string_control_char_escaper.f
rtl/jsce_pkg.sv
rtl/jsce_front.sv
rtl/jsce_queue.sv
rtl/jsce_back.sv
rtl/json_string_control_char_escaper.sv
rtl/jsce_checker.sv
sim/tb_json_string_control_char_escaper.sv
